/* hw/rtl/sle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CNT_W = 6;
    localparam int LEN_W = 5;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    localparam logic [1:0] CFG_ECHO_ENABLE = 2'd0;
    localparam logic [1:0] CFG_LINE_LIMIT  = 2'd1;

    localparam logic [5:0] LIMIT_MIN   = 6'd2;
    localparam logic [5:0] LIMIT_RESET = 6'd32;

    typedef enum logic [1:0] {
        CLS_EDIT,
        CLS_LF,
        CLS_CR,
        CLS_CHAR
    } t_cls;

    typedef enum logic [2:0] {
        OSEL_BS,
        OSEL_SP,
        OSEL_CR,
        OSEL_LF,
        OSEL_CHAR,
        OSEL_LINE,
        OSEL_EOL
    } t_osel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BS1,
        ST_SP,
        ST_BS2,
        ST_CR,
        ST_LF,
        ST_ECHO,
        ST_LPRE,
        ST_LINE,
        ST_EOL
    } t_state;

    typedef struct packed {
        logic  load_char;
        logic  store;
        logic  dec;
        logic  cnt_clr;
        logic  ovf_wr;
        logic  ovf_val;
        logic  idx_clr;
        logic  idx_inc;
        logic  out_load;
        t_osel osel;
        logic  out_last;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic cnt_zero;
        logic ovf_next;
        logic echo_en;
        logic idx_end;
        logic ovf_flag;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/sle_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sle_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_datapath
// Config registers, character count, line store and result register.
// ----------------------------------------------------------------------------
module sle_datapath #(
    parameter int LINE_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [5:0]       i_cfg_data,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_m_tready,
    input  sle_pkg::t_cmd    i_cmd,
    output sle_pkg::t_status o_status,
    output logic             o_m_tvalid,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_line_status,
    output logic [4:0]       o_line_length,
    output logic             o_last
);

    import sle_pkg::*;

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int CAP = (LINE_DEPTH < 32) ? LINE_DEPTH : 32;

    logic             r_echo_en;
    logic [5:0]       r_limit;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [7:0]       r_char;
    logic             r_ovf;
    logic             r_m_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_data;
    logic             r_stat;
    logic [4:0]       r_len;
    logic             r_last;

    logic [7:0]          w_fold;
    logic [5:0]          w_lim;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [AW+CNT_W-1:0] w_wext;
    logic [AW+CNT_W-1:0] w_rext;
    logic [7:0]          w_rdata;
    logic                w_out_free;
    t_cls                w_cls;

    always_comb begin
        if (i_rx_byte inside {[CH_UC_A:CH_UC_Z]}) begin
            w_fold = i_rx_byte + CASE_OFS;
        end else begin
            w_fold = i_rx_byte;
        end
    end

    always_comb begin
        if (w_fold == CH_BS || w_fold == CH_DEL) begin
            w_cls = CLS_EDIT;
        end else if (w_fold == CH_LF) begin
            w_cls = CLS_LF;
        end else if (w_fold == CH_CR) begin
            w_cls = CLS_CR;
        end else begin
            w_cls = CLS_CHAR;
        end
    end

    always_comb begin
        if (r_limit < LIMIT_MIN) begin
            w_lim = LIMIT_MIN;
        end else if (r_limit > 6'(CAP)) begin
            w_lim = 6'(CAP);
        end else begin
            w_lim = r_limit;
        end
    end

    assign w_cnt_inc  = r_count + 1'b1;
    assign w_out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.store) begin
            n_count = w_cnt_inc;
        end else if (i_cmd.dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
    end

    assign w_wext = {{AW{1'b0}}, r_count};
    assign w_rext = {{AW{1'b0}}, n_idx};

    sle_ram #(
        .WIDTH(8),
        .DEPTH(LINE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store),
        .i_waddr(w_wext[AW-1:0]),
        .i_wdata(w_fold),
        .i_raddr(w_rext[AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en <= 1'b1;
            r_limit   <= LIMIT_RESET;
            r_count   <= '0;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ECHO_ENABLE: r_echo_en <= i_cfg_data[0];
                    CFG_LINE_LIMIT:  r_limit   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.ovf_wr) begin
                r_ovf <= i_cmd.ovf_val;
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= w_fold;
        end
        if (i_cmd.out_load) begin
            r_last <= i_cmd.out_last;
            r_stat <= 1'b0;
            r_len  <= '0;
            case (i_cmd.osel)
                OSEL_BS: begin
                    r_kind <= KIND_ECHO;
                    r_data <= CH_BS;
                end
                OSEL_SP: begin
                    r_kind <= KIND_ECHO;
                    r_data <= CH_SPACE;
                end
                OSEL_CR: begin
                    r_kind <= KIND_ECHO;
                    r_data <= CH_CR;
                end
                OSEL_LF: begin
                    r_kind <= KIND_ECHO;
                    r_data <= CH_LF;
                end
                OSEL_CHAR: begin
                    r_kind <= KIND_ECHO;
                    r_data <= r_char;
                end
                OSEL_LINE: begin
                    r_kind <= KIND_LINE;
                    r_data <= w_rdata;
                end
                default: begin
                    r_kind <= KIND_EOL;
                    r_data <= '0;
                    r_stat <= r_ovf;
                    r_len  <= r_count[LEN_W-1:0];
                end
            endcase
        end
    end

    assign o_status.cls      = w_cls;
    assign o_status.cnt_zero = (r_count == '0);
    assign o_status.ovf_next = (w_cnt_inc >= (w_lim - 1'b1));
    assign o_status.echo_en  = r_echo_en;
    assign o_status.idx_end  = ((r_idx + 1'b1) == r_count);
    assign o_status.ovf_flag = r_ovf;
    assign o_status.out_free = w_out_free;

    assign o_m_tvalid    = r_m_valid;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_line_status = r_stat;
    assign o_line_length = r_len;
    assign o_last        = r_last;

endmodule

/* hw/rtl/sle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer for echo, edit and line emission of each received byte.
// ----------------------------------------------------------------------------
module sle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  sle_pkg::t_status i_status,
    output logic             o_s_tready,
    output sle_pkg::t_cmd    o_cmd
);

    import sle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_status.cls)
                        CLS_EDIT: begin
                            if (!i_status.cnt_zero && i_status.echo_en) begin
                                n_state = ST_BS1;
                            end
                        end
                        CLS_CR: begin
                            n_state = i_status.echo_en ? ST_CR : ST_LPRE;
                        end
                        CLS_CHAR: begin
                            if (i_status.echo_en) begin
                                n_state = ST_ECHO;
                            end else if (i_status.ovf_next) begin
                                n_state = ST_LPRE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_BS1:  if (i_status.out_free) n_state = ST_SP;
            ST_SP:   if (i_status.out_free) n_state = ST_BS2;
            ST_BS2:  if (i_status.out_free) n_state = ST_IDLE;
            ST_CR:   if (i_status.out_free) n_state = ST_LF;
            ST_LF:   if (i_status.out_free) n_state = ST_LPRE;
            ST_ECHO: begin
                if (i_status.out_free) begin
                    n_state = i_status.ovf_flag ? ST_LPRE : ST_IDLE;
                end
            end
            ST_LPRE: n_state = i_status.cnt_zero ? ST_EOL : ST_LINE;
            ST_LINE: begin
                if (i_status.out_free && i_status.idx_end) begin
                    n_state = ST_EOL;
                end
            end
            ST_EOL:  if (i_status.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.osel = OSEL_BS;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_char = 1'b1;
                    case (i_status.cls)
                        CLS_EDIT: o_cmd.dec = !i_status.cnt_zero;
                        CLS_CR: begin
                            o_cmd.ovf_wr  = 1'b1;
                            o_cmd.ovf_val = 1'b0;
                        end
                        CLS_CHAR: begin
                            o_cmd.store   = 1'b1;
                            o_cmd.ovf_wr  = 1'b1;
                            o_cmd.ovf_val = i_status.ovf_next;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BS1: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.osel     = OSEL_BS;
            end
            ST_SP: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.osel     = OSEL_SP;
            end
            ST_BS2: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.osel     = OSEL_BS;
                o_cmd.out_last = 1'b1;
            end
            ST_CR: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.osel     = OSEL_CR;
            end
            ST_LF: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.osel     = OSEL_LF;
            end
            ST_ECHO: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.osel     = OSEL_CHAR;
                o_cmd.out_last = !i_status.ovf_flag;
            end
            ST_LPRE: begin
                o_cmd.idx_clr = 1'b1;
            end
            ST_LINE: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.idx_inc  = i_status.out_free;
                o_cmd.osel     = OSEL_LINE;
            end
            ST_EOL: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.cnt_clr  = i_status.out_free;
                o_cmd.osel     = OSEL_EOL;
                o_cmd.out_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/serial_line_editor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor
// Terminal line editor: case folding, backspace/delete editing, echo and
// emission of completed or overflowed lines as a result stream.
// ----------------------------------------------------------------------------
// a taken byte that needs output starts its echo, edit echo or line sequence;
// the input is not ready again until the sequence is back in idle, so each byte
// is fully handled before the next is taken; output stalls hold the sequence
// line bytes stream from the line store RAM read port, one per cycle unless stalled
// reset: synchronous active low; clears count, state and output valid, sets
//   echo on and limit 32; the line store is not cleared
// ----------------------------------------------------------------------------
module serial_line_editor #(
    parameter int LINE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [8] line_status,
                                        // [13:9] line_length, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    import sle_pkg::*;

    t_cmd       w_cmd;
    t_status    w_status;
    logic [7:0] w_data_byte;
    logic       w_line_status;
    logic [4:0] w_line_length;

    sle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_status  (w_status),
        .o_s_tready(s_axis_tready),
        .o_cmd     (w_cmd)
    );

    sle_datapath #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rx_byte    (s_axis_tdata),
        .i_m_tready   (m_axis_tready),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_m_tvalid   (m_axis_tvalid),
        .o_kind       (m_axis_tuser),
        .o_data_byte  (w_data_byte),
        .o_line_status(w_line_status),
        .o_line_length(w_line_length),
        .o_last       (m_axis_tlast)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {2'b00, w_line_length, w_line_status, w_data_byte};

endmodule

/* hw/rtl/sle_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker
// Port level checks on the result stream of the serial line editor.
// ----------------------------------------------------------------------------
module sle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    import sle_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_EOL |->
            m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
        else $error("end of line not last or has data");

    a_line_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_LINE |->
            !m_axis_tlast && m_axis_tdata[13:8] == 6'd0)
        else $error("line byte marked last or has status");

    a_no_take_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_LINE |-> !s_axis_tready)
        else $error("input taken while a line is streaming");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

/* verif/serial_line_editor_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_test
// Self-checking bench for the serial line editor. A small scoreboard tracks the
// typed line, the echo setting and the line limit, and predicts the echo, line
// and end of line requests for every accepted byte. It then compares each
// output request with the oldest prediction. Opening bytes hit the edge
// cases: empty-line edits, line feed, case folding bounds, echo off, the
// minimum limit and a limit lowered mid line. Random phases under changing
// settings follow, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module serial_line_editor_test;
    import sle_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TARGET_BYTES   = 320;
    localparam int STORE_DEPTH    = 32;

    localparam logic [7:0] OPENING [14] = '{
        CH_BS, CH_DEL, CH_LF, CH_UC_A, CH_UC_Z, 8'h40, 8'h5B,
        8'h00, 8'hFF, 8'h80, CH_BS, CH_DEL, CH_CR, CH_CR
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       status;
        logic [4:0] length;
        logic       last;
    } t_result;

    class t_line_scoreboard;
        t_result     due_results[$];
        logic [7:0]  typed_chars [STORE_DEPTH];
        logic [5:0]  typed_cnt;
        logic        echo_on;
        logic [5:0]  limit_reg;
        int errors;
        int bytes_seen;
        int results_seen;
        int lines_ok;
        int lines_ovf;
        int cfg_writes;

        function new();
            typed_cnt = '0;
            echo_on = 1'b1;
            limit_reg = LIMIT_RESET;
            errors = 0;
            bytes_seen = 0;
            results_seen = 0;
            lines_ok = 0;
            lines_ovf = 0;
            cfg_writes = 0;
        endfunction

        function int pending_count();
            return due_results.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [5:0] val);
            cfg_writes++;
            case (idx)
                CFG_ECHO_ENABLE: begin
                    echo_on = val[0];
                end
                CFG_LINE_LIMIT: begin
                    limit_reg = val;
                end
                default: begin
                end
            endcase
        endfunction

        function logic [5:0] eff_limit();
            if (limit_reg < LIMIT_MIN) return LIMIT_MIN;
            if (limit_reg > STORE_DEPTH) return 6'(STORE_DEPTH);
            return limit_reg;
        endfunction

        function void push(logic [1:0] kind, logic [7:0] data, logic status,
                           logic [4:0] length);
            t_result r;
            r.kind = kind;
            r.data = data;
            r.status = status;
            r.length = length;
            r.last = 1'b0;
            due_results.push_back(r);
        endfunction

        function void flush_line(logic status);
            for (int i = 0; i < typed_cnt; i++) push(KIND_LINE, typed_chars[i], 1'b0, 5'd0);
            push(KIND_EOL, 8'h00, status, typed_cnt[4:0]);
            typed_cnt = '0;
            if (status) lines_ovf++;
            else lines_ok++;
        endfunction

        function void note_byte(logic [7:0] rx);
            logic [7:0] c;
            int n0;
            c = rx;
            n0 = due_results.size();
            bytes_seen++;
            if (c >= CH_UC_A && c <= CH_UC_Z) c = c + CASE_OFS;
            if (c == CH_BS || c == CH_DEL) begin
                if (typed_cnt != 0) begin
                    if (echo_on) begin
                        push(KIND_ECHO, CH_BS, 1'b0, 5'd0);
                        push(KIND_ECHO, CH_SPACE, 1'b0, 5'd0);
                        push(KIND_ECHO, CH_BS, 1'b0, 5'd0);
                    end
                    typed_cnt--;
                end
            end else if (c == CH_CR) begin
                if (echo_on) begin
                    push(KIND_ECHO, CH_CR, 1'b0, 5'd0);
                    push(KIND_ECHO, CH_LF, 1'b0, 5'd0);
                end
                flush_line(1'b0);
            end else if (c != CH_LF) begin
                if (typed_cnt < STORE_DEPTH) begin
                    typed_chars[typed_cnt] = c;
                    typed_cnt++;
                end
                if (echo_on) push(KIND_ECHO, c, 1'b0, 5'd0);
                if (typed_cnt >= eff_limit() - 6'd1) flush_line(1'b1);
            end
            if (due_results.size() > n0) due_results[due_results.size() - 1].last = 1'b1;
        endfunction

        function void compare(string name, int want_v, int got_v);
            if (want_v != got_v) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic status,
                                   logic [4:0] length, logic last);
            t_result want;
            results_seen++;
            if (due_results.size() == 0) begin
                $error("unexpected request: kind 0x%0h data 0x%0h", kind, data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare("kind", want.kind, kind);
            compare("data_byte", want.data, data);
            compare("line_status", want.status, status);
            compare("line_length", want.length, length);
            compare("last", want.last, last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_ECHO_ENABLE;
    logic [5:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_line_scoreboard sb;
    bit hold_rx = 1'b0;
    int sent_total = 0;
    int quiet_cycles = 0;

    serial_line_editor u_dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                                m_axis_tdata[13:9], m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: random back-pressure, one long hold when asked
    initial begin
        int gap;
        int run;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // wait for the clock first so the monitor has noted the last accepted byte
    task automatic end_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic echo, input logic [5:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ECHO_ENABLE;
        i_cfg_data <= {5'd0, echo};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_LINE_LIMIT;
        i_cfg_data <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly typed lines with edits ending in return, some raw noise
    task automatic run_phase(input logic echo, input logic [5:0] limit, input int n_bytes,
                             input bit burst);
        logic [7:0] seq[$];
        int counted;
        int len;
        int r;
        int cap;
        logic [7:0] b;
        counted = 0;
        cap = (limit < 2) ? 3 : ((limit > 32) ? 33 : limit + 1);
        set_config(echo, limit);
        while (counted < n_bytes) begin
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(0, cap);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 6) b = CH_BS;
                    else if (r < 11) b = CH_DEL;
                    else if (r < 20) b = 8'($urandom_range(CH_UC_A, CH_UC_Z));
                    else if (r < 25) b = 8'($urandom_range(0, 255));
                    else b = 8'($urandom_range(8'h20, 8'h7E));
                    seq.push_back(b);
                end
                if ($urandom_range(0, 9) != 0) seq.push_back(CH_CR);
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    b = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(0, 255));
                    seq.push_back(b);
                end
            end
            counted = 0;
            foreach (seq[i]) if (seq[i] != CH_LF) counted++;
        end
        foreach (seq[i]) send_byte(seq[i], burst);
        sent_total += counted;
        end_phase();
    endtask

    initial begin
        int r;
        logic [5:0] lim;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING[i]) send_byte(OPENING[i], 1'b0);
        end_phase();
        set_config(1'b0, 6'd32);
        send_byte("Q", 1'b0);
        send_byte(CH_BS, 1'b0);
        send_byte("x", 1'b0);
        send_byte(CH_CR, 1'b0);
        end_phase();
        set_config(1'b1, 6'd32);
        for (int i = 0; i < 5; i++) send_byte(8'h61 + 8'(i), 1'b0);
        end_phase();
        // limit dropped below the current count: next character overflows
        set_config(1'b1, 6'd3);
        send_byte("f", 1'b0);
        end_phase();
        set_config(1'b1, LIMIT_MIN);
        send_byte("g", 1'b0);
        end_phase();

        run_phase(1'b1, 6'd2, 20, 1'b0);
        run_phase(1'b0, 6'd32, 30, 1'b0);
        hold_rx = 1'b1;
        run_phase(1'b1, 6'd32, 45, 1'b1);
        run_phase(1'b1, 6'd63, 30, 1'b0);
        run_phase(1'b1, 6'd0, 15, 1'b0);
        run_phase(1'b0, 6'd1, 15, 1'b1);
        run_phase(1'b1, 6'd33, 25, 1'b0);
        while (sent_total < TARGET_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 50) lim = 6'($urandom_range(2, 8));
            else if (r < 80) lim = 6'($urandom_range(9, 32));
            else lim = 6'($urandom_range(0, 63));
            run_phase(1'($urandom_range(0, 1)), lim, $urandom_range(15, 35),
                      $urandom_range(0, 3) == 0);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending_count() != 0) begin
            $error("%0d predicted requests never arrived", sb.pending_count());
            sb.errors++;
        end
        $display("run: %0d bytes in, %0d requests out checked, %0d register writes",
                 sb.bytes_seen, sb.results_seen, sb.cfg_writes);
        $display("lines: %0d ended by return, %0d by overflow", sb.lines_ok, sb.lines_ovf);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
